>>> rtl/core/lcg_random_pick_without_repeat_macros.svh
// -----------------------------------------------------------------------------
// lcg_random_pick_without_repeat assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef LCG_RANDOM_PICK_WITHOUT_REPEAT_MACROS_SVH
`define LCG_RANDOM_PICK_WITHOUT_REPEAT_MACROS_SVH

// same-cycle implication
`define LCGPICK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCGPICK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lcgpick_pkg.sv
// -----------------------------------------------------------------------------
// lcgpick_pkg
// Shared types and constants of the random pick without repeat block.
// -----------------------------------------------------------------------------
package lcgpick_pkg;

    localparam int unsigned CFG_W       = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned SEED_W      = 8;
    localparam int unsigned GEN_W       = 32;
    localparam int unsigned IDX_OUT_W   = 6;
    localparam int unsigned ANGLE_W     = 16;
    localparam int unsigned DIV_STEPS   = 32;
    localparam int unsigned DIV_CNT_W   = 5;

    localparam logic [GEN_W-1:0] LCG_MUL = 32'h5d58_8b65;
    localparam logic [GEN_W-1:0] LCG_INC = 32'h0000_0001;
    localparam logic [CFG_W-1:0] MAX_RESULTS = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT   = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_STEP,
        S_DIV,
        S_PROBE,
        S_CHECK,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic div_shift;
        logic probe_adv;
        logic mark;
        logic emit;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic cfg_bad;
        logic no_picks;
        logic clear_last;
        logic div_last;
        logic probe_hit;
        logic out_free;
        logic last_pick;
    } t_status;

endpackage

>>> rtl/core/lcgpick_ctrl.sv
// -----------------------------------------------------------------------------
// lcgpick_ctrl
// Sequencer: seed load, map clear, LCG step, remainder, probe, emit and error.
// -----------------------------------------------------------------------------
module lcgpick_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  lcgpick_pkg::t_status i_status,
    output lcgpick_pkg::t_cmd    o_cmd
);
    import lcgpick_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_status.cfg_bad) begin
                        n_state = S_ERR;
                    end else if (!i_status.no_picks) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.probe_hit ? S_PROBE : S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_pick ? S_IDLE : S_STEP;
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = w_accept;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_shift = 1'b1;
            end
            S_CHECK: begin
                o_cmd.probe_adv = i_status.probe_hit;
                o_cmd.mark      = !i_status.probe_hit;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            S_ERR: begin
                o_cmd.emit_err = i_status.out_free;
            end
            default: begin
                o_cmd.step = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/lcgpick_dp.sv
// -----------------------------------------------------------------------------
// lcgpick_dp
// Datapath: config registers, generator, serial remainder, used map, output.
// -----------------------------------------------------------------------------
module lcgpick_dp #(
    parameter int unsigned MAX_SLOTS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lcgpick_pkg::t_cmd                      i_cmd,
    output lcgpick_pkg::t_status                   o_status,
    input  logic [lcgpick_pkg::SEED_W-1:0]         i_host_generation,
    input  logic                                   i_cfg_valid,
    input  logic [lcgpick_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcgpick_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [lcgpick_pkg::IDX_OUT_W-1:0]      o_anchor_index,
    output logic signed [lcgpick_pkg::ANGLE_W-1:0] o_angle,
    output logic                                   o_last,
    output logic                                   o_error
);
    import lcgpick_pkg::*;

    localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = CFG_W + 2;
    localparam logic [CW-1:0] SLOTS_LIMIT = CW'(MAX_SLOTS);

    logic [CFG_W-1:0]     r_anchor_count;
    logic [CFG_W-1:0]     r_pick_count;
    logic [GEN_W-1:0]     r_gen;
    logic [GEN_W-1:0]     r_div;
    logic [CFG_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [IW-1:0]        r_idx;
    logic [CFG_W-1:0]     r_tries;
    logic                 r_used_mem [MAX_SLOTS];
    logic                 r_used_rd;
    logic [IW-1:0]        r_clr_addr;
    logic [CFG_W-1:0]     r_picks_done;

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [ANGLE_W-1:0]   r_out_angle;
    logic                 r_out_last;
    logic                 r_out_error;

    logic [GEN_W-1:0]     w_next_gen;
    logic [CFG_W:0]       w_rem_shift;
    logic                 w_rem_ge;
    logic [CFG_W-1:0]     n_rem;
    logic [CW-1:0]        w_idx_inc;
    logic [IW-1:0]        n_idx_wrap;
    logic [CW-1:0]        w_clr_inc;

    assign w_next_gen  = r_gen * LCG_MUL + LCG_INC;
    assign w_rem_shift = {r_rem, r_div[GEN_W-1]};
    assign w_rem_ge    = (w_rem_shift >= {1'b0, r_anchor_count});
    assign n_rem       = w_rem_ge ? CFG_W'(w_rem_shift - {1'b0, r_anchor_count})
                                  : w_rem_shift[CFG_W-1:0];
    assign w_idx_inc   = CW'(r_idx) + CW'(1);
    assign n_idx_wrap  = (w_idx_inc == CW'(r_anchor_count)) ? '0 : IW'(w_idx_inc);
    assign w_clr_inc   = CW'(r_clr_addr) + CW'(1);

    always_comb begin
        o_status.cfg_bad    = (r_anchor_count == '0)
                           || (CW'(r_anchor_count) > SLOTS_LIMIT)
                           || (r_pick_count > r_anchor_count)
                           || (r_pick_count > MAX_RESULTS);
        o_status.no_picks   = (r_pick_count == '0);
        o_status.clear_last = (w_clr_inc == CW'(r_anchor_count));
        o_status.div_last   = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.probe_hit  = r_used_rd && (r_tries < r_anchor_count);
        o_status.out_free   = !r_out_valid || !i_stall;
        o_status.last_pick  = ((r_picks_done + CFG_W'(1)) == r_pick_count);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_count <= CFG_W'(1);
            r_pick_count   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ANCHOR_COUNT: r_anchor_count <= i_cfg_data;
                CFG_PICK_COUNT:   r_pick_count   <= i_cfg_data;
                default: begin
                    r_pick_count <= r_pick_count;
                end
            endcase
        end
    end

    // generator, remainder and probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gen <= GEN_W'(i_host_generation);
        end else if (i_cmd.step || i_cmd.emit) begin
            r_gen <= w_next_gen;
        end
        if (i_cmd.load) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= IW'(w_clr_inc);
        end
        if (i_cmd.step) begin
            r_div <= w_next_gen;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_shift) begin
            r_div <= {r_div[GEN_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.div_shift && o_status.div_last) begin
            r_idx   <= IW'(n_rem);
            r_tries <= '0;
        end else if (i_cmd.probe_adv) begin
            r_idx   <= n_idx_wrap;
            r_tries <= r_tries + CFG_W'(1);
        end
    end

    // used map: clear one slot per cycle, then mark picks
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_used_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.mark) begin
            r_used_mem[r_idx] <= 1'b1;
        end
        r_used_rd <= r_used_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picks_done <= '0;
        end else if (i_cmd.load) begin
            r_picks_done <= '0;
        end else if (i_cmd.emit) begin
            r_picks_done <= r_picks_done + CFG_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx   <= IDX_OUT_W'(r_idx);
            r_out_angle <= w_next_gen[ANGLE_W-1:0];
            r_out_last  <= o_status.last_pick;
            r_out_error <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out_idx   <= '0;
            r_out_angle <= '0;
            r_out_last  <= 1'b1;
            r_out_error <= 1'b1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_anchor_index = r_out_idx;
    assign o_angle        = $signed(r_out_angle);
    assign o_last         = r_out_last;
    assign o_error        = r_out_error;

endmodule

>>> rtl/core/lcg_random_pick_without_repeat.sv
// -----------------------------------------------------------------------------
// lcg_random_pick_without_repeat
// Picks distinct slots per request from a seeded 32-bit LCG with linear probing.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_stall      i_host_generation
//   output    out        o_valid / i_stall      o_anchor_index, o_angle,
//                                               o_last, o_error
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// After accept, the first anchor_count slots of the used map are cleared.
// Each pick runs a generator step, a serial remainder over the 32 generator
// bits, and a probe and a check per slot tried (H taken slots skipped, 0 to
// anchor_count - 1), then emit. An error request gives one error result.
// Reset is synchronous: anchor_count 1, pick_count 0, idle FSM, o_valid low.
// A stalled output holds emit; one result may wait while the next is computed.
// -----------------------------------------------------------------------------
`include "lcg_random_pick_without_repeat_macros.svh"

module lcg_random_pick_without_repeat #(
    parameter int unsigned MAX_SLOTS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [lcgpick_pkg::SEED_W-1:0]         i_host_generation,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [lcgpick_pkg::IDX_OUT_W-1:0]      o_anchor_index,
    output logic signed [lcgpick_pkg::ANGLE_W-1:0] o_angle,
    output logic                                   o_last,
    output logic                                   o_error,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [lcgpick_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcgpick_pkg::CFG_W-1:0]          i_cfg_data
);
    import lcgpick_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_emit_any;
    logic    w_start;

    assign o_cfg_ready = 1'b1;
    assign w_emit_any  = w_cmd.emit || w_cmd.emit_err;
    assign w_start     = i_valid && !o_stall && !w_status.cfg_bad && !w_status.no_picks;

    lcgpick_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    lcgpick_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_host_generation (i_host_generation),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_anchor_index    (o_anchor_index),
        .o_angle           (o_angle),
        .o_last            (o_last),
        .o_error           (o_error)
    );

    `LCGPICK_ASSERT_IMP(a_emit_needs_slot, w_emit_any, w_status.out_free, "emit into full output")
    `LCGPICK_ASSERT_IMP(a_error_is_last, o_valid && o_error, o_last, "error result without last")
    `LCGPICK_ASSERT_NXT(a_busy_after_start, w_start, o_stall, "not busy after start")

endmodule
